@@ rtl/fcds_pkg.sv @@
// shared types, constants and helpers for the cloud density sampler
`default_nettype none
package fcds_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int MAX_OCTAVES_DEF = 5;
	localparam int WARP_OCTAVES    = 2;
	localparam int LAT_W           = 19;
	localparam int TOT_W           = 27;
	localparam int OCT_W           = 4;

	localparam logic [31:0] COARSE_ZOOM = 32'd786;
	localparam logic [31:0] WARP_OFS_X = 32'd340787;
	localparam logic [31:0] WARP_OFS_Y = 32'd85197;
	localparam logic [31:0] WARP_BX = 32'((64'(WARP_OFS_X) * 64'(COARSE_ZOOM)) >> 16);
	localparam logic [31:0] WARP_BY = 32'((64'(WARP_OFS_Y) * 64'(COARSE_ZOOM)) >> 16);

	localparam logic [31:0] HASH_P1 = 32'd73856093;
	localparam logic [31:0] HASH_P2 = 32'd19349663;
	localparam logic [31:0] HASH_P3 = 32'd83492791;
	localparam logic [31:0] HASH_M1 = 32'h85ebca6b;
	localparam logic [31:0] HASH_M2 = 32'hc2b2ae35;

	// 1500 = 4 * 375, the odd part is checked through a reciprocal
	localparam logic [31:0] BOLT_ODD   = 32'd375;
	localparam logic [31:0] BOLT_RECIP = 32'd2932031007;
	localparam int          BOLT_SHIFT = 40;

	localparam int          RECIP_SHIFT = 26;
	localparam logic [2:0]  TIER_TOP    = 3'd4;
	localparam logic        CMD_LOAD    = 1'b0;
	localparam logic        CMD_SAMPLE  = 1'b1;

	typedef enum logic [2:0] {
		REG_SCALE_X,
		REG_SCALE_Y,
		REG_OCTAVE_COUNT,
		REG_WARP_AMOUNT,
		REG_WIND_SHARE,
		REG_TIER_CUTOFFS,
		REG_BOLT_ENABLE
	} reg_idx_t;

	typedef struct packed {
		logic        cmd;
		logic [9:0]  cell_x;
		logic [9:0]  cell_y;
		logic [31:0] drift_x;
		logic [31:0] drift_y;
		logic [31:0] swirl_time;
		logic [31:0] time_bucket;
		logic [7:0]  entry_index;
		logic [7:0]  entry_value;
	} sample_t;

	typedef struct packed {
		logic [15:0] density;
		logic [2:0]  tier;
		logic        bolt;
	} result_t;

	typedef struct packed {
		logic       we;
		logic [7:0] idx;
		logic [7:0] val;
	} lat_wr_t;

	// floor(2^26 / (2^n - 1))
	function automatic logic [RECIP_SHIFT:0] div_recip(input logic [OCT_W-1:0] n);
		logic [RECIP_SHIFT:0] r;
		case (n)
			4'd2:    r = 27'd22369621;
			4'd3:    r = 27'd9586980;
			4'd4:    r = 27'd4473924;
			4'd5:    r = 27'd2164802;
			4'd6:    r = 27'd1065220;
			4'd7:    r = 27'd528416;
			4'd8:    r = 27'd263172;
			default: r = 27'd67108864;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/fbm_cloud_density_sampler_core.sv @@
// cloud density sampler top level: warp, fbm density, tier and lightning
//
//   channel  | handshake                  | payload
//   sample   | sample_valid/sample_ready  | sample_t (load or sample item)
//   result   | result_valid/result_ready  | result_t (one per sample item)
//   config   | cfg_we                     | cfg_index, cfg_data
//
// one item per cycle unless a stalled result holds the pipeline; result_valid is registered
// a sample item passes two lattice lookups and two fbm divides in series
// the permutation table is held in per-lattice copies, written in pipeline order
// a stalled result freezes the whole pipeline, nothing is dropped or repeated
// reset clears valid bits and loads the register defaults, the table is not cleared
`default_nettype none
module fbm_cloud_density_sampler_core import fcds_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        sample_valid,
	output logic             sample_ready,
	input  wire sample_t     sample,
	output logic             result_valid,
	input  wire logic        result_ready,
	output result_t          result,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);
	localparam int NSTG = 19;

	typedef struct packed {
		logic        smp;
		logic [7:0]  idx;
		logic [7:0]  val;
		logic [31:0] wx;
		logic [31:0] wy;
		logic        hit;
	} pipe_t;

	logic [15:0] scale_x_q, scale_y_q;
	logic [2:0]  octave_count_q;
	logic [14:0] warp_amount_q, wind_share_q;
	logic [63:0] tier_cutoffs_q;
	logic        bolt_enable_q;

	logic        en;
	logic [NSTG:1] vld_s;
	pipe_t       dat_s [1:NSTG];
	logic [31:0] ax_s1, ay_s1, bx_s1, by_s1, bucket_s1;
	logic [9:0]  cx_s1, cy_s1;
	logic [31:0] hsh_s2, hsh_s3, hsh_s4, hsh_s5, bh_s6;
	logic [23:0] bq_s6;
	logic        result_vld_q;
	result_t     result_q;

	logic [OCT_W-1:0]        oct_n;
	lat_wr_t                 wr_warp, wr_main;
	logic signed [LAT_W-1:0] wqx [WARP_OCTAVES];
	logic signed [LAT_W-1:0] wqy [WARP_OCTAVES];
	logic signed [LAT_W-1:0] mn  [MAX_OCTAVES];
	logic signed [TOT_W-1:0] wtot_x, wtot_y, mtot, qx, qy, qm;
	logic [31:0]             brem;
	logic                    hit_c;
	logic [15:0]             dens;
	logic [2:0]              tier_c;
	logic [31:0]             wx_w, wy_w;

	function automatic logic [31:0] warp_ofs(input logic signed [TOT_W-1:0] qv,
			input logic [14:0] amt);
		logic signed [TOT_W+16:0] p;
		p = (TOT_W+17)'(qv) * (TOT_W+17)'($signed({1'b0, amt}));
		if (p < 0) p = p + (TOT_W+17)'(4095);
		return 32'(p >>> 12);
	endfunction

	assign en           = !result_vld_q || result_ready;
	assign sample_ready = en;
	assign result_valid = result_vld_q;
	assign result       = result_q;

	assign oct_n = (octave_count_q == 3'd0) ? OCT_W'(1) :
		(OCT_W'(octave_count_q) > OCT_W'(MAX_OCTAVES)) ? OCT_W'(MAX_OCTAVES) :
		OCT_W'(octave_count_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q      <= 16'd1638;
			scale_y_q      <= 16'd3277;
			octave_count_q <= 3'd4;
			warp_amount_q  <= 15'd12288;
			wind_share_q   <= 15'd16384;
			tier_cutoffs_q <= 64'd15680053348335648768;
			bolt_enable_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCALE_X:      scale_x_q      <= cfg_data[15:0];
				REG_SCALE_Y:      scale_y_q      <= cfg_data[15:0];
				REG_OCTAVE_COUNT: octave_count_q <= cfg_data[2:0];
				REG_WARP_AMOUNT:  warp_amount_q  <= cfg_data[14:0];
				REG_WIND_SHARE:   wind_share_q   <= cfg_data[14:0];
				REG_TIER_CUTOFFS: tier_cutoffs_q <= cfg_data;
				REG_BOLT_ENABLE:  bolt_enable_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s        <= '0;
			result_vld_q <= 1'b0;
		end else if (en) begin
			vld_s        <= {vld_s[NSTG-1:1], sample_valid};
			result_vld_q <= vld_s[NSTG] && dat_s[NSTG].smp;
		end
	end

	// lightning hash
	assign brem  = bh_s6 - 32'(bq_s6) * BOLT_ODD;
	assign hit_c = (bh_s6[1:0] == 2'b00) && (brem == 32'd0 || brem == BOLT_ODD);

	// warp offsets
	assign wx_w = (warp_amount_q != 15'd0) ? dat_s[9].wx + warp_ofs(qx, warp_amount_q)
		: dat_s[9].wx;
	assign wy_w = (warp_amount_q != 15'd0) ? dat_s[9].wy + warp_ofs(qy, warp_amount_q)
		: dat_s[9].wy;

	// data path
	always_ff @(posedge clk) begin
		if (en) begin
			dat_s[1].smp <= (sample.cmd == CMD_SAMPLE);
			dat_s[1].idx <= sample.entry_index;
			dat_s[1].val <= sample.entry_value;
			dat_s[1].wx  <= 32'({sample.cell_x, 16'h0000})
				+ 32'((64'(sample.drift_x) * 64'(wind_share_q)) >> 14);
			dat_s[1].wy  <= 32'({sample.cell_y, 16'h0000}) + sample.drift_y;
			dat_s[1].hit <= 1'b0;
			for (int k = 2; k <= NSTG; k++) begin
				if (k != 7 && k != 10 && k != 11) dat_s[k] <= dat_s[k-1];
			end

			ax_s1     <= 32'(sample.cell_x) * COARSE_ZOOM;
			ay_s1     <= 32'(sample.cell_y) * COARSE_ZOOM + sample.swirl_time;
			bx_s1     <= 32'(sample.cell_x) * COARSE_ZOOM + WARP_BX;
			by_s1     <= 32'(sample.cell_y) * COARSE_ZOOM + WARP_BY + sample.swirl_time;
			cx_s1     <= sample.cell_x;
			cy_s1     <= sample.cell_y;
			bucket_s1 <= sample.time_bucket;

			hsh_s2 <= (32'(cx_s1) * HASH_P1) ^ (32'(cy_s1) * HASH_P2) ^ (bucket_s1 * HASH_P3);
			hsh_s3 <= (hsh_s2 ^ (hsh_s2 >> 16)) * HASH_M1;
			hsh_s4 <= (hsh_s3 ^ (hsh_s3 >> 13)) * HASH_M2;
			hsh_s5 <= hsh_s4 ^ (hsh_s4 >> 16);
			bq_s6  <= 24'((64'(hsh_s5) * 64'(BOLT_RECIP)) >> BOLT_SHIFT);
			bh_s6  <= hsh_s5;
			dat_s[7] <= '{smp: dat_s[6].smp, idx: dat_s[6].idx, val: dat_s[6].val,
				wx: dat_s[6].wx, wy: dat_s[6].wy, hit: hit_c};

			dat_s[10] <= '{smp: dat_s[9].smp, idx: dat_s[9].idx, val: dat_s[9].val,
				wx: wx_w, wy: wy_w, hit: dat_s[9].hit};
			dat_s[11] <= '{smp: dat_s[10].smp, idx: dat_s[10].idx, val: dat_s[10].val,
				wx: 32'((48'(dat_s[10].wx) * 48'(scale_x_q)) >> 16),
				wy: 32'((48'(dat_s[10].wy) * 48'(scale_y_q)) >> 16),
				hit: dat_s[10].hit};

			result_q.density <= dens;
			result_q.tier    <= tier_c;
			result_q.bolt    <= bolt_enable_q && (tier_c == TIER_TOP) && dat_s[NSTG].hit;
		end
	end

	// warp lattices
	assign wr_warp = '{we: vld_s[1] && !dat_s[1].smp, idx: dat_s[1].idx, val: dat_s[1].val};

	for (genvar o = 0; o < WARP_OCTAVES; o++) begin : g_warp
		fcds_lattice #(.TABLE_DEPTH(TABLE_DEPTH)) u_qx (
			.clk(clk), .arst_n(arst_n), .en(en), .wr(wr_warp),
			.x(ax_s1 << o), .y(ay_s1 << o), .val(wqx[o])
		);
		fcds_lattice #(.TABLE_DEPTH(TABLE_DEPTH)) u_qy (
			.clk(clk), .arst_n(arst_n), .en(en), .wr(wr_warp),
			.x(bx_s1 << o), .y(by_s1 << o), .val(wqy[o])
		);
	end

	always_comb begin
		wtot_x = '0;
		wtot_y = '0;
		for (int o = 0; o < WARP_OCTAVES; o++) begin
			wtot_x = (wtot_x <<< 1) + TOT_W'(wqx[o]);
			wtot_y = (wtot_y <<< 1) + TOT_W'(wqy[o]);
		end
	end

	fcds_fbm_div u_div_qx (
		.clk(clk), .en(en), .total(wtot_x), .n(OCT_W'(WARP_OCTAVES)), .q(qx)
	);
	fcds_fbm_div u_div_qy (
		.clk(clk), .en(en), .total(wtot_y), .n(OCT_W'(WARP_OCTAVES)), .q(qy)
	);

	// density lattices
	assign wr_main = '{we: vld_s[11] && !dat_s[11].smp, idx: dat_s[11].idx,
		val: dat_s[11].val};

	for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_main
		fcds_lattice #(.TABLE_DEPTH(TABLE_DEPTH)) u_oct (
			.clk(clk), .arst_n(arst_n), .en(en), .wr(wr_main),
			.x(dat_s[11].wx << o), .y(dat_s[11].wy << o), .val(mn[o])
		);
	end

	always_comb begin
		mtot = '0;
		for (int o = 0; o < MAX_OCTAVES; o++) begin
			if (o < int'(oct_n)) mtot = (mtot <<< 1) + TOT_W'(mn[o]);
		end
	end

	fcds_fbm_div u_div_main (
		.clk(clk), .en(en), .total(mtot), .n(oct_n), .q(qm)
	);

	// saturation and grading
	always_comb begin
		if (qm[TOT_W-1])         dens = 16'h0000;
		else if (|qm[TOT_W-2:16]) dens = 16'hffff;
		else                     dens = qm[15:0];
		tier_c = TIER_TOP;
		for (int k = 3; k >= 0; k--) begin
			if (dens < tier_cutoffs_q[16*k +: 16]) tier_c = 3'(k);
		end
	end

`ifndef SYNTHESIS
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s[NSTG] && !dat_s[NSTG].smp |=> !result_valid)
		else $error("load item produced a result");
	a_sample_result: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s[NSTG] && dat_s[NSTG].smp |=> result_valid)
		else $error("sample item lost at pipeline end");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |=> $stable(vld_s))
		else $error("pipeline moved during stall");
	a_bolt_top_tier: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!result.bolt || result.tier == TIER_TOP))
		else $error("lightning outside densest tier");
	a_tier_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.tier <= TIER_TOP)
		else $error("tier out of range");
`endif

endmodule
`default_nettype wire

@@ rtl/fcds_lattice.sv @@
// one gradient noise lookup: table reads, fade curves, gradients and three lerps
`default_nettype none
module fcds_lattice import fcds_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire lat_wr_t                 wr,
	input  wire logic [31:0]             x,
	input  wire logic [31:0]             y,
	output logic signed [LAT_W-1:0]      val
);
	localparam int IW = $clog2(TABLE_DEPTH);

	logic [7:0] mem_a [TABLE_DEPTH];
	logic [7:0] mem_b [TABLE_DEPTH];
	logic [7:0] mem_c [TABLE_DEPTH];

	lat_wr_t                 wr_s1;
	logic [7:0]              pa_s1, pb_s1;
	logic [IW-1:0]           gy_s1;
	logic [15:0]             fx_s1, fy_s1, tx2_s1, ty2_s1;

	logic [7:0]              h00_s2, h01_s2, h10_s2, h11_s2;
	logic [15:0]             fx_s2, fy_s2, tx3_s2, ty3_s2;
	logic [19:0]             inx_s2, iny_s2;

	logic [16:0]             u_s3, v_s3, v_s4;
	logic signed [LAT_W-1:0] n00_s3, n01_s3, n10_s3, n11_s3;
	logic signed [LAT_W-1:0] e0_s4, e1_s4, val_s5;

	logic [IW-1:0] gx, ra, rb;
	logic signed [17:0] dx0, dx1, dy0, dy1;

	function automatic logic signed [LAT_W-1:0] slope(input logic [2:0] h,
			input logic signed [17:0] dx, input logic signed [17:0] dy);
		logic signed [LAT_W-1:0] u, v;
		u = (h < 3'd4) ? LAT_W'(dx) : LAT_W'(dy);
		v = (h < 3'd4) ? LAT_W'(dy) : LAT_W'(dx);
		u = h[0] ? -u : u;
		v = h[1] ? -(v <<< 1) : (v <<< 1);
		return u + v;
	endfunction

	function automatic logic signed [LAT_W-1:0] blend(input logic signed [LAT_W-1:0] a,
			input logic signed [LAT_W-1:0] b, input logic [16:0] t);
		logic signed [LAT_W:0]    d;
		logic signed [LAT_W+18:0] p;
		d = (LAT_W+1)'(b) - (LAT_W+1)'(a);
		p = (LAT_W+19)'(d) * (LAT_W+19)'($signed({1'b0, t}));
		if (p < 0) p = p + (LAT_W+19)'(65535);
		return a + LAT_W'(p >>> 16);
	endfunction

	assign gx  = x[16 +: IW];
	assign ra  = IW'(pa_s1) + gy_s1;
	assign rb  = IW'(pb_s1) + gy_s1;
	assign dx0 = 18'(fx_s2);
	assign dy0 = 18'(fy_s2);
	assign dx1 = 18'(fx_s2) - 18'sd65536;
	assign dy1 = 18'(fy_s2) - 18'sd65536;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1 <= '0;
		end else if (en) begin
			wr_s1 <= wr;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (wr.we) mem_a[IW'(wr.idx)] <= wr.val;
			pa_s1  <= mem_a[gx];
			pb_s1  <= mem_a[gx + 1'b1];
			gy_s1  <= y[16 +: IW];
			fx_s1  <= x[15:0];
			fy_s1  <= y[15:0];
			tx2_s1 <= 16'((32'(x[15:0]) * 32'(x[15:0])) >> 16);
			ty2_s1 <= 16'((32'(y[15:0]) * 32'(y[15:0])) >> 16);

			if (wr_s1.we) begin
				mem_b[IW'(wr_s1.idx)] <= wr_s1.val;
				mem_c[IW'(wr_s1.idx)] <= wr_s1.val;
			end
			h00_s2 <= mem_b[ra];
			h01_s2 <= mem_b[ra + 1'b1];
			h10_s2 <= mem_c[rb];
			h11_s2 <= mem_c[rb + 1'b1];
			fx_s2  <= fx_s1;
			fy_s2  <= fy_s1;
			tx3_s2 <= 16'((32'(tx2_s1) * 32'(fx_s1)) >> 16);
			ty3_s2 <= 16'((32'(ty2_s1) * 32'(fy_s1)) >> 16);
			inx_s2 <= 20'(21'd655360 + 21'(tx2_s1) * 21'd6 - 21'(fx_s1) * 21'd15);
			iny_s2 <= 20'(21'd655360 + 21'(ty2_s1) * 21'd6 - 21'(fy_s1) * 21'd15);

			u_s3   <= 17'((37'(tx3_s2) * 37'(inx_s2)) >> 16);
			v_s3   <= 17'((37'(ty3_s2) * 37'(iny_s2)) >> 16);
			n00_s3 <= slope(h00_s2[2:0], dx0, dy0);
			n10_s3 <= slope(h10_s2[2:0], dx1, dy0);
			n01_s3 <= slope(h01_s2[2:0], dx0, dy1);
			n11_s3 <= slope(h11_s2[2:0], dx1, dy1);

			e0_s4  <= blend(n00_s3, n10_s3, u_s3);
			e1_s4  <= blend(n01_s3, n11_s3, u_s3);
			v_s4   <= v_s3;

			val_s5 <= blend(e0_s4, e1_s4, v_s4);
		end
	end

	assign val = val_s5;

endmodule
`default_nettype wire

@@ rtl/fcds_fbm_div.sv @@
// fbm normalization: signed total over 2*(2^n-1), truncated, plus one half
`default_nettype none
module fcds_fbm_div import fcds_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic signed [TOT_W-1:0] total,
	input  wire logic [OCT_W-1:0]        n,
	output logic signed [TOT_W-1:0]      q
);
	logic [TOT_W-1:0]       mag_abs;
	logic [TOT_W-3:0]       mag_s1, mag_s2, q_s2;
	logic                   neg_s1, neg_s2;
	logic [OCT_W-1:0]       n_s1;
	logic [7:0]             d_s2;
	logic signed [TOT_W-1:0] q_s3;
	logic [TOT_W-3:0]       rem, qf;
	logic [2*TOT_W:0]       prod;

	assign mag_abs = total[TOT_W-1] ? TOT_W'(-total) : TOT_W'(total);
	assign prod    = (2*TOT_W+1)'(mag_s1) * (2*TOT_W+1)'(div_recip(n_s1));
	assign rem     = mag_s2 - (TOT_W-2)'(q_s2 * (TOT_W-2)'(d_s2));
	assign qf      = q_s2 + (TOT_W-2)'(rem >= (TOT_W-2)'(d_s2));

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_abs[TOT_W-2:1];
			neg_s1 <= total[TOT_W-1];
			n_s1   <= n;

			q_s2   <= (TOT_W-2)'(prod >> RECIP_SHIFT);
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			d_s2   <= 8'((9'd1 << n_s1) - 9'd1);

			q_s3   <= neg_s2 ? TOT_W'(32768) - TOT_W'(qf) : TOT_W'(32768) + TOT_W'(qf);
		end
	end

	assign q = q_s3;

endmodule
`default_nettype wire
